// ===== design/wsel_pkg.sv =====
// Shared constants and types of the window sum extreme locator.
package wsel_pkg;

	localparam int CFG_W     = 7;
	localparam int SUM_OUT_W = 12;
	localparam int POS_OUT_W = 6;
	localparam int OUT_DATA_W = 56;

	localparam logic [CFG_W-1:0] DIM_RESET = 7'd10;

	typedef enum logic [0:0] {
		CFG_NUM_ROWS = 1'b0,
		CFG_NUM_COLS = 1'b1
	} cfg_reg_t;

	// Packed so that window_found lands in the lowest bit.
	typedef struct packed {
		logic [POS_OUT_W-1:0] smallest_col;
		logic [POS_OUT_W-1:0] smallest_row;
		logic [SUM_OUT_W-1:0] smallest_sum;
		logic [POS_OUT_W-1:0] largest_col;
		logic [POS_OUT_W-1:0] largest_row;
		logic [SUM_OUT_W-1:0] largest_sum;
		logic                 window_found;
	} result_t;

endpackage

// ===== design/wsel_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module wsel_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// A read at the address being written returns the old contents.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== design/window_sum_extreme_locator_core.sv =====
// Top level: 3x3 box sum maximum and minimum locator over a raster-order matrix.
// Output: m_tvalid is registered; the last item passes the stage one register, then sets it when stage one advances.
// Throughput: one item per cycle, set by the single registered pass behind the line store
// read ports; the only stall is a finished result that has not been taken yet.
// Reset: asynchronous, active low; both dimensions return to 10, the position and all
// window and best-so-far state clear, and the line stores keep whatever they hold.
module window_sum_extreme_locator_core
	import wsel_pkg::*;
#(
	parameter int MAX_DIM      = 64,
	parameter int ELEMENT_BITS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Configuration write port.
	input  logic                  cfg_we,
	input  logic [0:0]            cfg_index,
	input  logic [CFG_W-1:0]      cfg_data,
	// Input stream. tdata: element_value[7:0].
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,
	// Result stream. tdata: window_found[0], largest_sum[12:1], largest_row[18:13],
	// largest_col[24:19], smallest_sum[36:25], smallest_row[42:37],
	// smallest_col[48:43], zero padding above.
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata
);

	localparam int CW   = $clog2(MAX_DIM);
	localparam int DW   = $clog2(MAX_DIM + 1);
	localparam int EB   = ELEMENT_BITS;
	localparam int EXTW = (EB > 8) ? EB : 8;
	localparam int CSW  = EB + 2;
	localparam int WSW  = EB + 4;

	// ------------------------------------------------------------------
	// Configuration registers and effective dimensions.
	// ------------------------------------------------------------------
	logic [CFG_W-1:0] num_rows_q, num_cols_q;
	logic [DW-1:0]    rows_eff, cols_eff;
	logic             restart;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_rows_q <= DIM_RESET;
			num_cols_q <= DIM_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_NUM_ROWS: num_rows_q <= cfg_data;
				CFG_NUM_COLS: num_cols_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Every write to an existing register restarts the matrix.
	assign restart = cfg_we;

	// A dimension of zero acts as one; anything above MAX_DIM acts as MAX_DIM.
	always_comb begin
		if (num_rows_q == '0) begin
			rows_eff = DW'(1);
		end else if (32'(num_rows_q) > MAX_DIM) begin
			rows_eff = DW'(MAX_DIM);
		end else begin
			rows_eff = DW'(num_rows_q);
		end
		if (num_cols_q == '0) begin
			cols_eff = DW'(1);
		end else if (32'(num_cols_q) > MAX_DIM) begin
			cols_eff = DW'(MAX_DIM);
		end else begin
			cols_eff = DW'(num_cols_q);
		end
	end

	// ------------------------------------------------------------------
	// Handshake. Stage one always advances unless it holds
	// the last item of a matrix while the previous result is still waiting.
	// ------------------------------------------------------------------
	logic s_accept, s1_adv;
	logic valid_s1, last_s1;
	logic out_valid_q;

	assign s1_adv   = valid_s1 && (!last_s1 || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || s1_adv;
	assign s_accept = s_tvalid && s_tready;

	// ------------------------------------------------------------------
	// Position counters on the accept side. The column counter doubles as
	// the read address of both line stores.
	// ------------------------------------------------------------------
	logic [CW-1:0] row_q, col_q;
	logic [CW:0]   col_inc, row_inc;
	logic          col_wrap, row_wrap;

	assign col_inc  = (CW + 1)'(col_q) + 1'b1;
	assign row_inc  = (CW + 1)'(row_q) + 1'b1;
	assign col_wrap = col_inc >= (CW + 1)'(cols_eff);
	assign row_wrap = row_inc >= (CW + 1)'(rows_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (restart) begin
			row_q <= '0;
			col_q <= '0;
		end else if (s_accept) begin
			if (col_wrap) begin
				col_q <= '0;
				row_q <= row_wrap ? '0 : row_inc[CW-1:0];
			end else begin
				col_q <= col_inc[CW-1:0];
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage one register: the item, its position and a bypass for the case
	// where the line store entry is written in the very cycle it is read
	// (a single-column matrix).
	// ------------------------------------------------------------------
	logic [EXTW-1:0] elem_ext;
	logic [EB-1:0]   value_s1;
	logic [CW-1:0]   row_s1, col_s1;
	logic            byp_s1;
	logic [EB-1:0]   byp_up_s1, byp_mid_s1;
	logic [EB-1:0]   up_rd, mid_rd, up_eff, mid_eff;

	assign elem_ext = EXTW'(s_tdata);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_accept;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			value_s1   <= elem_ext[EB-1:0];
			row_s1     <= row_q;
			col_s1     <= col_q;
			last_s1    <= col_wrap && row_wrap;
			byp_s1     <= s1_adv && (col_s1 == col_q);
			byp_up_s1  <= mid_eff;
			byp_mid_s1 <= value_s1;
		end
	end

	assign up_eff  = byp_s1 ? byp_up_s1  : up_rd;
	assign mid_eff = byp_s1 ? byp_mid_s1 : mid_rd;

	// The upper store takes the old middle row; the middle store takes the new item.
	wsel_ram #(.WIDTH(EB), .DEPTH(MAX_DIM)) u_upper_line (
		.clk     (clk),
		.wr_en   (s1_adv),
		.wr_addr (col_s1),
		.wr_data (mid_eff),
		.rd_en   (s_accept),
		.rd_addr (col_q),
		.rd_data (up_rd)
	);

	wsel_ram #(.WIDTH(EB), .DEPTH(MAX_DIM)) u_middle_line (
		.clk     (clk),
		.wr_en   (s1_adv),
		.wr_addr (col_s1),
		.wr_data (value_s1),
		.rd_en   (s_accept),
		.rd_addr (col_q),
		.rd_data (mid_rd)
	);

	// ------------------------------------------------------------------
	// Column sums, window sum and best-so-far tracking.
	// ------------------------------------------------------------------
	logic [CSW-1:0] colsum, csw1_q, csw2_q;
	logic [WSW-1:0] win_sum;
	logic           win_here;
	logic [CW-1:0]  win_row, win_col;

	logic           seen_q, seen_nx;
	logic [WSW-1:0] hi_sum_q, hi_sum_nx, lo_sum_q, lo_sum_nx;
	logic [CW-1:0]  hi_row_q, hi_row_nx, hi_col_q, hi_col_nx;
	logic [CW-1:0]  lo_row_q, lo_row_nx, lo_col_q, lo_col_nx;

	assign colsum   = CSW'(up_eff) + CSW'(mid_eff) + CSW'(value_s1);
	assign win_sum  = WSW'(csw1_q) + WSW'(csw2_q) + WSW'(colsum);
	assign win_here = (row_s1 >= CW'(2)) && (col_s1 >= CW'(2));
	assign win_row  = row_s1 - CW'(2);
	assign win_col  = col_s1 - CW'(2);

	// Ties keep the earlier window: only a strictly better sum replaces it.
	always_comb begin
		seen_nx   = seen_q;
		hi_sum_nx = hi_sum_q;
		hi_row_nx = hi_row_q;
		hi_col_nx = hi_col_q;
		lo_sum_nx = lo_sum_q;
		lo_row_nx = lo_row_q;
		lo_col_nx = lo_col_q;
		if (win_here) begin
			seen_nx = 1'b1;
			if (!seen_q || (win_sum > hi_sum_q)) begin
				hi_sum_nx = win_sum;
				hi_row_nx = win_row;
				hi_col_nx = win_col;
			end
			if (!seen_q || (win_sum < lo_sum_q)) begin
				lo_sum_nx = win_sum;
				lo_row_nx = win_row;
				lo_col_nx = win_col;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			csw1_q   <= '0;
			csw2_q   <= '0;
			seen_q   <= 1'b0;
			hi_sum_q <= '0;
			hi_row_q <= '0;
			hi_col_q <= '0;
			lo_sum_q <= '0;
			lo_row_q <= '0;
			lo_col_q <= '0;
		end else if (restart || (s1_adv && last_s1)) begin
			csw1_q   <= '0;
			csw2_q   <= '0;
			seen_q   <= 1'b0;
			hi_sum_q <= '0;
			hi_row_q <= '0;
			hi_col_q <= '0;
			lo_sum_q <= '0;
			lo_row_q <= '0;
			lo_col_q <= '0;
		end else if (s1_adv) begin
			csw1_q   <= csw2_q;
			csw2_q   <= colsum;
			seen_q   <= seen_nx;
			hi_sum_q <= hi_sum_nx;
			hi_row_q <= hi_row_nx;
			hi_col_q <= hi_col_nx;
			lo_sum_q <= lo_sum_nx;
			lo_row_q <= lo_row_nx;
			lo_col_q <= lo_col_nx;
		end
	end

	// ------------------------------------------------------------------
	// Result register. With no window in the matrix every field is zero.
	// ------------------------------------------------------------------
	result_t res_nx, res_q;

	always_comb begin
		res_nx = '0;
		if (seen_nx) begin
			res_nx.window_found = 1'b1;
			res_nx.largest_sum  = SUM_OUT_W'(hi_sum_nx);
			res_nx.largest_row  = POS_OUT_W'(hi_row_nx);
			res_nx.largest_col  = POS_OUT_W'(hi_col_nx);
			res_nx.smallest_sum = SUM_OUT_W'(lo_sum_nx);
			res_nx.smallest_row = POS_OUT_W'(lo_row_nx);
			res_nx.smallest_col = POS_OUT_W'(lo_col_nx);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && last_s1) begin
			res_q <= res_nx;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_DATA_W'(res_q);

	// ------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------
	// The input side only backs up behind a finished matrix whose result waits.
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && last_s1 && out_valid_q && !m_tready))
		else $error("input stalled without a pending result");

	// A new result only appears after the last item of a matrix left stage one.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(s1_adv && last_s1))
		else $error("result appeared without a finished matrix");

	// Once seeded, the smallest sum never exceeds the largest.
	assert property (@(posedge clk) disable iff (!arst_n)
		seen_q |-> (lo_sum_q <= hi_sum_q))
		else $error("best sums out of order");

endmodule
